### hdl/delimiter_field_splitter_top_assert.svh
// Assertion macros for the delimiter field splitter checker.
// Both macros sample on clk and are switched off while arst_n is low.
`ifndef DELIMITER_FIELD_SPLITTER_TOP_ASSERT_SVH
`define DELIMITER_FIELD_SPLITTER_TOP_ASSERT_SVH
// Consequent checked in the same cycle as the antecedent.
`define DFS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("delimiter field splitter check failed");
// Consequent checked in the cycle after the antecedent.
`define DFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("delimiter field splitter check failed");
`endif

### hdl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and codes of the delimiter field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

	localparam int WIN_MAX = 4;
	localparam int FILL_W  = 3;

	localparam logic REG_DELIM_BYTES = 1'b0;
	localparam logic REG_DELIM_LEN   = 1'b1;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic {
		PH_RUN,
		PH_DONE
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [2:0]  field_index;
		logic        truncated;
		logic [2:0]  kept_count;
		logic [15:0] delimiter_total;
	} result_t;

	typedef struct packed {
		logic              append;
		logic              load;
		logic [FILL_W-1:0] shamt;
	} cell_ctl_t;

	typedef struct packed {
		logic push;
		logic fin;
		logic settled;
	} stage_req_t;

endpackage

`default_nettype wire

### hdl/delimiter_field_splitter_top.sv
// ----------------------------------------------------------------------------
// delimiter_field_splitter_top
// Splits a byte stream into fields at a 1 to 4 byte delimiter.
//
// Input s_axis: one byte per request, tlast on the final byte of a string.
// Output m_axis: one result per request; tuser gives the kind (data byte,
// field end, string done), tlast marks the last result caused by a byte.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 delimiter bytes,
// 1 delimiter length); write only while the block is idle. A window held
// across a write is matched against the new delimiter with the next byte.
// A result is staged at the step that makes it and moves to the output once
// the next step shows whether it is the last of its byte.
// Throughput: one byte per cycle while each byte settles in one window step
// and the results find room. Every further delimiter found, byte released or
// byte dropped from the window takes one more step; the final byte adds one
// step for the field end and one for the done result.
// Reset: delimiter ',' of length 1, window empty, counts cleared.
// Stall: results wait in the staging and output registers; no new byte is
// taken while a result for it could not be stored.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_field_splitter_top #(
	parameter int MAX_FIELDS    = 8,
	parameter int MAX_FIELD_LEN = 32,
	parameter int MAX_DELIM_LEN = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [10:8] field_index,
	                                    // [11] truncated, [14:12] kept_count,
	                                    // [30:15] delimiter_total, [31] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
	output logic        m_axis_tlast
);
	import dfs_pkg::*;

	localparam int WIN_DEPTH = (MAX_DELIM_LEN < WIN_MAX) ? MAX_DELIM_LEN : WIN_MAX;
	localparam int CW        = $clog2(MAX_FIELDS + 1);
	localparam int LW        = $clog2(MAX_FIELD_LEN);

	logic [31:0]       delim_q;
	logic [2:0]        dlen_q;
	logic [FILL_W-1:0] fill_q;
	logic [CW-1:0]     cur_q;
	logic [LW-1:0]     flen_q;
	logic              ovf_q;
	logic              cap_q;
	logic [15:0]       total_q;
	logic              last_q;
	logic              pend_q;
	phase_t            phase_q;

	logic [FILL_W-1:0] fill_nx;
	logic [CW-1:0]     cur_nx;
	logic [LW-1:0]     flen_nx;
	logic              ovf_nx;
	logic              cap_nx;
	logic [15:0]       total_nx;
	logic              last_nx;
	logic              pend_nx;
	phase_t            phase_nx;

	logic [WIN_DEPTH-1:0][7:0]              e_byte;
	logic [WIN_DEPTH-1:0]                   w_match;
	logic [WIN_DEPTH-1:0]                   e_match;
	logic [WIN_DEPTH-1:0]                   tail;
	logic [WIN_DEPTH-1:0][WIN_MAX-1:0][7:0] nbr;
	cell_ctl_t                              cell_ctl;

	logic [2:0]        eff_len;
	logic [FILL_W-1:0] fe;
	logic              prefix_w;
	logic              prefix_e;
	logic              full_e;
	logic              quiet_w;
	logic              settled_w;
	logic              step_en;
	logic              acc;
	logic              last_e;
	logic              room;
	logic              adv;
	logic              r_valid;
	logic              r_fin;
	logic [FILL_W-1:0] shamt;
	logic [CW-1:0]     kept;
	result_t           r_data;
	result_t           out_data;
	stage_req_t        stage_req;

	// delimiter length, 0 taken as 1, clamped to what the window can hold
	always_comb begin
		if (dlen_q == 3'd0) begin
			eff_len = 3'd1;
		end else if (dlen_q > 3'(WIN_DEPTH)) begin
			eff_len = 3'(WIN_DEPTH);
		end else begin
			eff_len = dlen_q;
		end
	end

	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		dfs_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.tail       (tail[i]),
			.in_byte    (s_axis_tdata),
			.delim_byte (delim_q[8*i +: 8]),
			.nbr        (nbr[i]),
			.e_byte     (e_byte[i]),
			.w_match    (w_match[i]),
			.e_match    (e_match[i])
		);
	end

	always_comb begin
		nbr = '0;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			tail[i] = (fill_q == FILL_W'(i));
			for (int k = 0; k < WIN_MAX; k++) begin
				if (i + k + 1 < WIN_DEPTH) begin
					nbr[i][k] = e_byte[i + k + 1];
				end
			end
		end
	end

	// every held window byte matches its delimiter byte (a delimiter prefix)
	always_comb begin
		prefix_w = 1'b1;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (FILL_W'(i) < fill_q && !w_match[i]) begin
				prefix_w = 1'b0;
			end
		end
	end

	// with no byte pending the window only moves when the next byte comes
	assign quiet_w   = prefix_w && (fill_q < eff_len);
	assign settled_w = (phase_q == PH_RUN) && !last_q && (!pend_q || quiet_w);
	assign s_axis_tready = settled_w && room;
	assign acc     = s_axis_tvalid && s_axis_tready;
	assign step_en = acc || pend_q || last_q;
	assign last_e  = last_q || (acc && s_axis_tlast);
	assign fe      = fill_q + {{(FILL_W-1){1'b0}}, acc};

	always_comb begin
		prefix_e = 1'b1;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (FILL_W'(i) < fe && FILL_W'(i) < eff_len && !e_match[i]) begin
				prefix_e = 1'b0;
			end
		end
	end

	assign full_e = prefix_e && (fe >= eff_len);
	assign kept   = cap_q ? CW'(MAX_FIELDS - 1) : cur_q;

	// one window step per cycle while results find room in the result stage
	always_comb begin
		fill_nx  = fe;
		cur_nx   = cur_q;
		flen_nx  = flen_q;
		ovf_nx   = ovf_q;
		cap_nx   = cap_q;
		total_nx = total_q;
		last_nx  = last_e;
		pend_nx  = acc || (pend_q && !quiet_w);
		phase_nx = phase_q;
		shamt    = '0;
		r_valid  = 1'b0;
		r_fin    = 1'b0;
		r_data   = '0;
		r_data.field_index = 3'(cur_q);
		r_data.truncated   = ovf_q;
		unique case (phase_q)
			PH_RUN: begin
				if (step_en && full_e) begin
					shamt   = eff_len;
					fill_nx = fe - eff_len;
					if (total_q != 16'hFFFF) begin
						total_nx = total_q + 16'd1;
					end
					if (!cap_q) begin
						r_valid     = 1'b1;
						r_data.kind = KIND_END;
						cur_nx      = cur_q + 1'b1;
						flen_nx     = '0;
						ovf_nx      = 1'b0;
						cap_nx      = (cur_q == CW'(MAX_FIELDS - 1));
					end
				end else if (step_en && fe != '0 && (!prefix_e || last_e)) begin
					shamt   = FILL_W'(1);
					fill_nx = fe - FILL_W'(1);
					if (!cap_q) begin
						if (flen_q == LW'(MAX_FIELD_LEN - 1)) begin
							ovf_nx = 1'b1;
						end else begin
							r_valid          = 1'b1;
							r_data.kind      = KIND_DATA;
							r_data.data_byte = e_byte[0];
							flen_nx          = flen_q + 1'b1;
						end
					end
				end else if (fe == '0 && last_e) begin
					phase_nx = PH_DONE;
					if (!cap_q) begin
						r_valid     = 1'b1;
						r_data.kind = KIND_END;
					end
				end
			end
			PH_DONE: begin
				r_valid                = 1'b1;
				r_fin                  = 1'b1;
				r_data.kind            = KIND_DONE;
				r_data.field_index     = 3'(kept);
				r_data.truncated       = 1'b0;
				r_data.kept_count      = 3'(kept);
				r_data.delimiter_total = total_q;
				fill_nx  = '0;
				cur_nx   = '0;
				flen_nx  = '0;
				ovf_nx   = 1'b0;
				cap_nx   = 1'b0;
				total_nx = '0;
				last_nx  = 1'b0;
				pend_nx  = 1'b0;
				phase_nx = PH_RUN;
			end
		endcase
	end

	assign adv = !r_valid || room;

	assign cell_ctl.append = acc;
	assign cell_ctl.load   = adv;
	assign cell_ctl.shamt  = shamt;

	assign stage_req.push    = r_valid && adv;
	assign stage_req.fin     = r_fin;
	assign stage_req.settled = settled_w;

	dfs_result_stage u_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (stage_req),
		.r_data    (r_data),
		.out_ready (m_axis_tready),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_data  (out_data),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tuser = out_data.kind;
	assign m_axis_tdata = {1'b0, out_data.delimiter_total, out_data.kept_count,
		out_data.truncated, out_data.field_index, out_data.data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= 32'd44;
			dlen_q  <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELIM_BYTES: delim_q <= cfg_wdata;
				REG_DELIM_LEN:   dlen_q  <= cfg_wdata[2:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RUN;
		end else if (adv) begin
			phase_q <= phase_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			cur_q   <= '0;
			flen_q  <= '0;
			ovf_q   <= 1'b0;
			cap_q   <= 1'b0;
			total_q <= '0;
			last_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else if (adv) begin
			fill_q  <= fill_nx;
			cur_q   <= cur_nx;
			flen_q  <= flen_nx;
			ovf_q   <= ovf_nx;
			cap_q   <= cap_nx;
			total_q <= total_nx;
			last_q  <= last_nx;
			pend_q  <= pend_nx;
		end
	end

endmodule

`default_nettype wire

### hdl/dfs_cell.sv
// ----------------------------------------------------------------------------
// dfs_cell
// One byte of the match window: holds a byte, compares it with its
// delimiter byte and takes a byte from a neighbour when the window shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_cell (
	input  logic                                clk,
	input  dfs_pkg::cell_ctl_t                  ctl,
	input  logic                                tail,
	input  logic [7:0]                          in_byte,
	input  logic [7:0]                          delim_byte,
	input  logic [dfs_pkg::WIN_MAX-1:0][7:0]    nbr,
	output logic [7:0]                          e_byte,
	output logic                                w_match,
	output logic                                e_match
);
	import dfs_pkg::*;

	logic [7:0] byte_q;
	logic [7:0] byte_nx;

	assign e_byte  = (ctl.append && tail) ? in_byte : byte_q;
	assign w_match = (byte_q == delim_byte);
	assign e_match = (e_byte == delim_byte);

	always_comb begin
		case (ctl.shamt)
			3'd1:    byte_nx = nbr[0];
			3'd2:    byte_nx = nbr[1];
			3'd3:    byte_nx = nbr[2];
			3'd4:    byte_nx = nbr[3];
			default: byte_nx = e_byte;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= byte_nx;
		end
	end

endmodule

`default_nettype wire

### hdl/dfs_result_stage.sv
// ----------------------------------------------------------------------------
// dfs_result_stage
// Staging and output registers. A result waits in staging until it is known
// whether it is the last one of its byte, then moves to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_result_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  dfs_pkg::stage_req_t req,
	input  dfs_pkg::result_t    r_data,
	input  logic                out_ready,
	output logic                room,
	output logic                out_valid,
	output dfs_pkg::result_t    out_data,
	output logic                out_last
);
	import dfs_pkg::*;

	logic    s_valid_q;
	logic    s_fin_q;
	result_t s_q;
	logic    o_valid_q;
	logic    o_last_q;
	result_t o_q;

	logic o_free;
	logic fin_e;
	logic s_move;

	assign o_free = !o_valid_q || out_ready;
	assign fin_e  = s_fin_q || req.settled;
	assign s_move = s_valid_q && o_free && (fin_e || req.push);
	assign room   = !s_valid_q || o_free;

	assign out_valid = o_valid_q;
	assign out_data  = o_q;
	assign out_last  = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid_q <= 1'b0;
			s_fin_q   <= 1'b0;
			o_valid_q <= 1'b0;
			o_last_q  <= 1'b0;
		end else begin
			if (req.push) begin
				s_valid_q <= 1'b1;
				s_fin_q   <= req.fin;
			end else if (s_move) begin
				s_valid_q <= 1'b0;
				s_fin_q   <= 1'b0;
			end else if (s_valid_q) begin
				s_fin_q <= fin_e;
			end
			if (s_move) begin
				o_valid_q <= 1'b1;
				o_last_q  <= fin_e;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push) begin
			s_q <= r_data;
		end
		if (s_move) begin
			o_q <= s_q;
		end
	end

endmodule

`default_nettype wire

### hdl/dfs_checker.sv
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks on the result stream of the delimiter field splitter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "delimiter_field_splitter_top_assert.svh"

module dfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import dfs_pkg::*;

	`DFS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
	`DFS_ASSERT_SAME(a_done_last, m_axis_tvalid && m_axis_tuser == KIND_DONE, m_axis_tlast)
	`DFS_ASSERT_SAME(a_done_fields, m_axis_tvalid && m_axis_tuser == KIND_DONE, m_axis_tdata[10:8] == m_axis_tdata[14:12] && !m_axis_tdata[11] && m_axis_tdata[7:0] == 8'd0)
	`DFS_ASSERT_SAME(a_counts_zero, m_axis_tvalid && m_axis_tuser != KIND_DONE, m_axis_tdata[31:12] == 20'd0)

endmodule

bind delimiter_field_splitter_top dfs_checker u_dfs_checker (.*);

`default_nettype wire

### test/tb_delimiter_field_splitter_top.sv
// ----------------------------------------------------------------------------
// tb_delimiter_field_splitter_top
// Self-checking bench for the delimiter field splitter.
//
// A directed table covers single-byte strings, zero bytes, the field cap,
// multi-byte and saturated delimiters and a delimiter change mid-string.
// Random strings of fields follow under several delimiter settings and
// handshake idling patterns. Every result is checked field by field
// against a behavioural model of the splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_delimiter_field_splitter_top;

	import dfs_pkg::*;

	localparam int MAX_FIELDS    = 8;
	localparam int MAX_FIELD_LEN = 32;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int RAND_ITEMS    = 400;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_b;
		logic [2:0]  field;
		logic        trunc;
		logic [2:0]  kept;
		logic [15:0] total;
		logic        last;
	} split_item_t;

	typedef enum {ROW_BYTE, ROW_CFG} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [31:0] val;
		logic [2:0]  len;
		bit          last;
		bit          typed;
		int          kept;
		int          total;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_DELIM_BYTES;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	delimiter_field_splitter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// splitter model state
	logic [7:0]  win [8];
	int          win_fill, cur_field, fld_len, delim_total;
	bit          fld_ovf, capped;
	logic [31:0] cfg_delim = 32'h0000_002C;
	logic [2:0]  cfg_len = 3'd1;

	split_item_t step_out[$];
	split_item_t split_due[$];
	dir_row_t    dir_rows[$];

	int mismatches = 0;
	int sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_done = 0;

	function automatic int delim_len_eff();
		int l;
		l = cfg_len;
		if (l == 0) l = 1;
		if (l > 4) l = 4;
		return l;
	endfunction

	function automatic void add_result(kind_t k, logic [7:0] b, int idx, bit tr, int kept,
			int tot);
		split_item_t it;
		if (step_out.size() >= 6) return;
		it.kind = k;
		it.data_b = b;
		it.field = idx[2:0];
		it.trunc = tr;
		it.kept = kept[2:0];
		it.total = tot[15:0];
		it.last = 1'b0;
		step_out.push_back(it);
	endfunction

	function automatic void drop_front(int k);
		if (k >= win_fill) begin
			win_fill = 0;
			return;
		end
		for (int i = 0; i < win_fill - k; i++)
			win[i] = win[i + k];
		win_fill -= k;
	endfunction

	function automatic void keep_byte(logic [7:0] b);
		if (capped) return;
		if (fld_len >= MAX_FIELD_LEN - 1) begin
			fld_ovf = 1'b1;
			return;
		end
		add_result(KIND_DATA, b, cur_field, fld_ovf, 0, 0);
		fld_len++;
	endfunction

	function automatic void found_delim(int len);
		drop_front(len);
		if (delim_total < 16'hFFFF) delim_total++;
		if (capped) return;
		add_result(KIND_END, 8'h00, cur_field, fld_ovf, 0, 0);
		cur_field++;
		fld_len = 0;
		fld_ovf = 1'b0;
		if (cur_field >= MAX_FIELDS) capped = 1'b1;
	endfunction

	function automatic void clear_string();
		for (int i = 0; i < 8; i++)
			win[i] = 8'h00;
		win_fill = 0;
		cur_field = 0;
		fld_len = 0;
		fld_ovf = 1'b0;
		capped = 1'b0;
		delim_total = 0;
	endfunction

	function automatic void split_step(logic [7:0] b, bit last);
		int len, m, kept;
		bit pre;
		step_out.delete();
		if (win_fill < 8) begin
			win[win_fill] = b;
			win_fill++;
		end
		while (win_fill > 0) begin
			len = delim_len_eff();
			m = (win_fill < len) ? win_fill : len;
			pre = 1'b1;
			for (int k = 0; k < m; k++)
				if (win[k] != cfg_delim[8*k +: 8]) pre = 1'b0;
			if (pre && win_fill >= len) begin
				found_delim(len);
				continue;
			end
			if (pre) break;
			keep_byte(win[0]);
			drop_front(1);
		end
		if (last) begin
			for (int k = 0; k < win_fill; k++)
				keep_byte(win[k]);
			win_fill = 0;
			if (!capped) add_result(KIND_END, 8'h00, cur_field, fld_ovf, 0, 0);
			kept = capped ? MAX_FIELDS - 1 : cur_field;
			add_result(KIND_DONE, 8'h00, kept, 1'b0, kept, delim_total);
			clear_string();
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i])
			split_due.push_back(step_out[i]);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [7:0] rand_byte();
		int k;
		if ($urandom_range(99) < 65) return 8'($urandom_range(255));
		k = $urandom_range(delim_len_eff() - 1);
		return cfg_delim[8*k +: 8];
	endfunction

	task automatic send_byte(logic [7:0] b, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		split_step(b, last);
		sent++;
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (split_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_delimiter(logic [31:0] bytes, logic [2:0] len);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_DELIM_BYTES;
		cfg_wdata <= bytes;
		@(posedge clk);
		cfg_delim = bytes;
		cfg_index <= REG_DELIM_LEN;
		cfg_wdata <= {29'b0, len};
		@(posedge clk);
		cfg_len = len;
		cfg_we <= 1'b0;
	endtask

	task automatic send_string();
		int nf, flen, dl, n;
		dl = delim_len_eff();
		if ($urandom_range(99) < 15) begin
			flen = $urandom_range(1, 12);
			for (int i = 0; i < flen; i++)
				send_byte(rand_byte(), i == flen - 1);
			return;
		end
		nf = ($urandom_range(99) < 10) ? $urandom_range(8, 11) : $urandom_range(1, 5);
		for (int f = 0; f < nf; f++) begin
			flen = ($urandom_range(99) < 10) ? $urandom_range(28, 40) : $urandom_range(0, 6);
			for (int i = 0; i < flen; i++)
				send_byte(rand_byte(), 1'b0);
			if (f < nf - 1) begin
				// now and then a broken delimiter
				n = ($urandom_range(99) < 10) ? $urandom_range(dl - 1) : dl;
				for (int k = 0; k < n; k++)
					send_byte(cfg_delim[8*k +: 8], 1'b0);
			end
		end
		send_byte(rand_byte(), 1'b1);
	endtask

	function automatic void add_byte_row(logic [7:0] b, bit last, bit typed, int kept,
			int total);
		dir_row_t r;
		r.op = ROW_BYTE;
		r.val = {24'b0, b};
		r.len = 3'd0;
		r.last = last;
		r.typed = typed;
		r.kept = kept;
		r.total = total;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_cfg_row(logic [31:0] bytes, logic [2:0] len);
		dir_row_t r;
		r.op = ROW_CFG;
		r.val = bytes;
		r.len = len;
		r.last = 1'b0;
		r.typed = 1'b0;
		r.kept = 0;
		r.total = 0;
		dir_rows.push_back(r);
	endfunction

	// result side
	initial begin
		split_item_t exp_r;
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (split_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got kind %0d data %h",
						$time, m_axis_tuser, m_axis_tdata);
					mismatches++;
				end else begin
					exp_r = split_due.pop_front();
					check_field("out_kind", exp_r.kind, m_axis_tuser);
					check_field("out_byte", exp_r.data_b, m_axis_tdata[7:0]);
					check_field("field_index", exp_r.field, m_axis_tdata[10:8]);
					check_field("truncated", exp_r.trunc, m_axis_tdata[11]);
					check_field("kept_count", exp_r.kept, m_axis_tdata[14:12]);
					check_field("delimiter_total", exp_r.total, m_axis_tdata[30:15]);
					check_field("pad", 0, m_axis_tdata[31]);
					check_field("run_last", exp_r.last, m_axis_tlast);
				end
			end
			if (hold_asked != hold_done) begin
				stall_left = HOLD_CYCLES;
				hold_done = hold_asked;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stimulus
	initial begin
		dir_row_t r;
		int target;
		logic [31:0] bytes;
		logic [2:0] len_tab [8];
		len_tab = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6};
		clear_string();

		// byte, last, typed, kept_count, delimiter_total
		add_byte_row("a", 1'b0, 1'b0, 0, 0);
		add_byte_row(",", 1'b0, 1'b0, 0, 0);
		add_byte_row("b", 1'b1, 1'b1, 1, 1);
		add_byte_row(8'h00, 1'b1, 1'b1, 0, 0);
		add_byte_row(",", 1'b1, 1'b1, 1, 1);
		for (int i = 0; i < 8; i++)
			add_byte_row(",", 1'b0, 1'b0, 0, 0);
		add_byte_row(",", 1'b1, 1'b1, 7, 9);
		add_cfg_row(32'h0000_6261, 3'd2);
		add_byte_row("a", 1'b0, 1'b0, 0, 0);
		add_byte_row("a", 1'b0, 1'b0, 0, 0);
		add_byte_row("b", 1'b1, 1'b1, 1, 1);
		add_cfg_row(32'h007A_7978, 3'd3);
		add_byte_row("x", 1'b0, 1'b0, 0, 0);
		add_byte_row("y", 1'b0, 1'b0, 0, 0);
		add_cfg_row(32'h007A_7978, 3'd1);
		add_byte_row("q", 1'b1, 1'b1, 1, 1);
		add_cfg_row(32'h0000_0000, 3'd0);
		add_byte_row(8'h00, 1'b1, 1'b1, 1, 1);
		add_cfg_row(32'hFFFF_FFFF, 3'd7);
		for (int i = 0; i < 3; i++)
			add_byte_row(8'hFF, 1'b0, 1'b0, 0, 0);
		add_byte_row(8'hFF, 1'b1, 1'b1, 1, 1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.op == ROW_CFG) begin
				set_delimiter(r.val, r.len);
			end else begin
				send_byte(r.val[7:0], r.last);
				if (r.typed) begin
					split_due[split_due.size() - 1].field = r.kept[2:0];
					split_due[split_due.size() - 1].kept = r.kept[2:0];
					split_due[split_due.size() - 1].total = r.total[15:0];
				end
			end
		end

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: bytes = 32'h0000_002C;
				3: bytes = 32'hFFFF_FFFF;
				5: bytes = 32'h0000_0000;
				default: bytes = $urandom_range(1) ? {4{8'($urandom)}} : $urandom;
			endcase
			set_delimiter(bytes, len_tab[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 71;
				end
				default: begin
					send_idle_pct = 11;
					stall_pct = 11;
				end
			endcase
			// long output hold-off while requests keep coming
			if (p == 4) hold_asked++;
			target = sent + RAND_ITEMS / 8;
			while (sent < target) begin
				if ($urandom_range(9) == 0) wait_drain();
				send_string();
			end
		end

		wait_drain();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/dfs_pkg.sv
hdl/dfs_cell.sv
hdl/dfs_result_stage.sv
hdl/delimiter_field_splitter_top.sv
hdl/dfs_checker.sv
test/tb_delimiter_field_splitter_top.sv
